// ===== sv/absm_pkg.sv =====
// shared types and codes of the a/b boot slot manager
package absm_pkg;

    localparam int VER_W    = 32;
    localparam int TRIAL_W  = 8;
    localparam int SLOT_W   = 8;
    localparam int MODE_W   = 3;
    localparam int STATE_W  = 3;
    localparam int DEC_W    = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CANDIDATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONFIRM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROLLBACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MARK_BAD  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SELECT    = 3'd5;

    localparam logic [STATE_W-1:0] ST_EMPTY     = 3'd0;
    localparam logic [STATE_W-1:0] ST_CANDIDATE = 3'd1;
    localparam logic [STATE_W-1:0] ST_CONFIRMED = 3'd2;
    localparam logic [STATE_W-1:0] ST_ACTIVE    = 3'd3;
    localparam logic [STATE_W-1:0] ST_BAD       = 3'd4;

    localparam logic [DEC_W-1:0] DEC_ACTIVE   = 2'd0;
    localparam logic [DEC_W-1:0] DEC_FALLBACK = 2'd1;
    localparam logic [DEC_W-1:0] DEC_STAY     = 2'd2;

    typedef struct packed {
        logic               active;
        logic [STATE_W-1:0] slot0_st;
        logic [STATE_W-1:0] slot1_st;
        logic [VER_W-1:0]   confirmed_ver;
        logic [VER_W-1:0]   candidate_ver;
        logic [TRIAL_W-1:0] trial_count;
        logic               rollback;
    } boot_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  slot;
        logic [VER_W-1:0]   version;
        logic [TRIAL_W-1:0] trial_budget;
        logic               consume_trial;
    } boot_event_t;

    typedef struct packed {
        logic               ok;
        logic [DEC_W-1:0]   decision;
        logic               boot_slot;
        logic               active_now;
        logic [STATE_W-1:0] active_slot_state;
        logic [VER_W-1:0]   confirmed_ver_out;
        logic [VER_W-1:0]   candidate_ver_out;
        logic [TRIAL_W-1:0] trials_left;
        logic               rollback_pending;
    } boot_result_t;

    function automatic logic is_good(input logic [STATE_W-1:0] st);
        return (st == ST_CONFIRMED) || (st == ST_ACTIVE);
    endfunction

endpackage

// ===== sv/absm_event_unit.sv =====
// next boot-control state and result for one event
module absm_event_unit (
    input  absm_pkg::boot_state_t  cur,
    input  absm_pkg::boot_event_t  evt,
    output absm_pkg::boot_state_t  nxt,
    output absm_pkg::boot_result_t res
);

    logic                         slot_ok;
    logic                         fb;
    logic [absm_pkg::STATE_W-1:0] act_st;
    logic [absm_pkg::STATE_W-1:0] fb_st;
    logic [absm_pkg::STATE_W-1:0] nxt_act_st;
    logic                         need_fb;

    assign slot_ok = (evt.slot[absm_pkg::SLOT_W-1:1] == '0);
    assign fb      = ~cur.active;
    assign act_st  = cur.active ? cur.slot1_st : cur.slot0_st;
    assign fb_st   = cur.active ? cur.slot0_st : cur.slot1_st;
    assign need_fb = cur.rollback || (act_st == absm_pkg::ST_BAD) ||
                     (act_st == absm_pkg::ST_EMPTY) ||
                     ((act_st == absm_pkg::ST_CANDIDATE) && (cur.trial_count == '0));

    always_comb begin
        nxt          = cur;
        res          = '0;
        unique case (evt.mode)
            absm_pkg::MODE_INIT: begin
                if (slot_ok) begin
                    nxt.active        = evt.slot[0];
                    nxt.confirmed_ver = evt.version;
                    nxt.candidate_ver = '0;
                    nxt.trial_count   = '0;
                    nxt.rollback      = 1'b0;
                    nxt.slot0_st      = evt.slot[0] ? absm_pkg::ST_EMPTY
                                                    : absm_pkg::ST_CONFIRMED;
                    nxt.slot1_st      = evt.slot[0] ? absm_pkg::ST_CONFIRMED
                                                    : absm_pkg::ST_EMPTY;
                    res.ok            = 1'b1;
                end
            end
            absm_pkg::MODE_CANDIDATE: begin
                if (slot_ok && (evt.trial_budget != '0) && (evt.version != '0)) begin
                    nxt.active = evt.slot[0];
                    if (evt.slot[0]) begin
                        nxt.slot1_st = absm_pkg::ST_CANDIDATE;
                    end else begin
                        nxt.slot0_st = absm_pkg::ST_CANDIDATE;
                    end
                    nxt.candidate_ver = evt.version;
                    nxt.trial_count   = evt.trial_budget;
                    nxt.rollback      = 1'b0;
                    res.ok            = 1'b1;
                end
            end
            absm_pkg::MODE_CONFIRM: begin
                if (cur.active) begin
                    nxt.slot1_st = absm_pkg::ST_CONFIRMED;
                end else begin
                    nxt.slot0_st = absm_pkg::ST_CONFIRMED;
                end
                if (cur.candidate_ver != '0) begin
                    nxt.confirmed_ver = cur.candidate_ver;
                end
                nxt.candidate_ver = '0;
                nxt.trial_count   = '0;
                nxt.rollback      = 1'b0;
                res.ok            = 1'b1;
            end
            absm_pkg::MODE_ROLLBACK: begin
                nxt.rollback = 1'b1;
                res.ok       = 1'b1;
            end
            absm_pkg::MODE_MARK_BAD: begin
                if (slot_ok) begin
                    if (evt.slot[0]) begin
                        nxt.slot1_st = absm_pkg::ST_BAD;
                    end else begin
                        nxt.slot0_st = absm_pkg::ST_BAD;
                    end
                    if (cur.active == evt.slot[0]) begin
                        nxt.candidate_ver = '0;
                        nxt.trial_count   = '0;
                        nxt.rollback      = 1'b1;
                    end
                    res.ok = 1'b1;
                end
            end
            absm_pkg::MODE_SELECT: begin
                priority if (need_fb) begin
                    if (absm_pkg::is_good(fb_st)) begin
                        if ((act_st == absm_pkg::ST_CANDIDATE) || cur.rollback) begin
                            if (cur.active) begin
                                nxt.slot1_st = absm_pkg::ST_BAD;
                            end else begin
                                nxt.slot0_st = absm_pkg::ST_BAD;
                            end
                            nxt.candidate_ver = '0;
                        end
                        nxt.active      = fb;
                        nxt.rollback    = 1'b0;
                        nxt.trial_count = '0;
                        res.decision    = absm_pkg::DEC_FALLBACK;
                        res.boot_slot   = fb;
                        res.ok          = 1'b1;
                    end else begin
                        res.decision = absm_pkg::DEC_STAY;
                    end
                end else if (act_st == absm_pkg::ST_CANDIDATE) begin
                    if (evt.consume_trial) begin
                        nxt.trial_count = cur.trial_count -
                                          {{(absm_pkg::TRIAL_W-1){1'b0}}, 1'b1};
                    end
                    res.decision  = absm_pkg::DEC_ACTIVE;
                    res.boot_slot = cur.active;
                    res.ok        = 1'b1;
                end else if (absm_pkg::is_good(act_st)) begin
                    res.decision  = absm_pkg::DEC_ACTIVE;
                    res.boot_slot = cur.active;
                    res.ok        = 1'b1;
                end else begin
                    res.decision = absm_pkg::DEC_STAY;
                end
            end
            default: begin
            end
        endcase

        nxt_act_st            = nxt.active ? nxt.slot1_st : nxt.slot0_st;
        res.active_now        = nxt.active;
        res.active_slot_state = nxt_act_st;
        res.confirmed_ver_out = nxt.confirmed_ver;
        res.candidate_ver_out = nxt.candidate_ver;
        res.trials_left       = nxt.trial_count;
        res.rollback_pending  = nxt.rollback;
    end

endmodule

// ===== sv/ab_boot_slot_manager_core.sv =====
// top level of the a/b boot slot manager
//
// usage: one event transaction in on the s_ channel (mode in s_tuser, the
// other fields in s_tdata), one result transaction out on the m_ channel for
// every event, in order. an accepted event sits in an input register; when it
// advances, the event unit updates the boot-control state and loads the
// result register, which drives m_tvalid. throughput is one event per cycle
// while the receiver takes results: the state update is a single pass of
// compares and muxes between the input register and the state/result
// registers, so an event can follow its predecessor immediately.
// when the receiver stalls, the result register holds and the input register
// still takes one more event; s_tready drops only when both are full and
// m_tready is low.
// reset (aresetn low, synchronous) empties both registers and returns the
// state to: slot 0 active and confirmed, slot 1 empty, versions, trial count
// and rollback flag zero.
module ab_boot_slot_manager_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slot[7:0], version[39:8], trial_budget[47:40], consume_trial[48], zero fill
    input  logic [absm_pkg::S_DATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [absm_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok[0], decision[2:1], boot_slot[3], active_now[4], active_slot_state[7:5],
    // confirmed_ver_out[39:8], candidate_ver_out[71:40], trials_left[79:72],
    // rollback_pending[80], zero fill
    output logic [absm_pkg::M_DATA_W-1:0]  m_tdata
);

    logic                   in_valid_reg;
    absm_pkg::boot_event_t  evt_reg;
    logic                   out_valid_reg;
    absm_pkg::boot_result_t res_reg;
    absm_pkg::boot_state_t  state_reg;
    absm_pkg::boot_state_t  state_next;
    absm_pkg::boot_result_t res_next;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    absm_event_unit u_event (
        .cur (state_reg),
        .evt (evt_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.active        <= 1'b0;
            state_reg.slot0_st      <= absm_pkg::ST_CONFIRMED;
            state_reg.slot1_st      <= absm_pkg::ST_EMPTY;
            state_reg.confirmed_ver <= '0;
            state_reg.candidate_ver <= '0;
            state_reg.trial_count   <= '0;
            state_reg.rollback      <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            evt_reg.mode          <= s_tuser;
            evt_reg.slot          <= s_tdata[7:0];
            evt_reg.version       <= s_tdata[39:8];
            evt_reg.trial_budget  <= s_tdata[47:40];
            evt_reg.consume_trial <= s_tdata[48];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       res_reg.rollback_pending,
                       res_reg.trials_left,
                       res_reg.candidate_ver_out,
                       res_reg.confirmed_ver_out,
                       res_reg.active_slot_state,
                       res_reg.active_now,
                       res_reg.boot_slot,
                       res_reg.decision,
                       res_reg.ok};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !m_tvalid)
        else $error("pipeline not empty after reset");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed event produced no result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    a_fallback_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_reg.decision == absm_pkg::DEC_FALLBACK) |->
            res_reg.ok && !res_reg.rollback_pending && (res_reg.trials_left == '0))
        else $error("fallback left trial or rollback state behind");

endmodule
